// ----- src/dae_pkg.sv -----
// Shared types, codes and constants for the DNS A-record extractor.
package dae_pkg;

    // Parse phases; the codes above PH_ERR_RCODE mean nothing.
    typedef enum logic [3:0] {
        PH_HEADER      = 4'd0,
        PH_QNAME       = 4'd1,
        PH_QPTR        = 4'd2,
        PH_QLABEL      = 4'd3,
        PH_QFIXED      = 4'd4,
        PH_ANAME       = 4'd5,
        PH_APTR        = 4'd6,
        PH_ALABEL      = 4'd7,
        PH_AFIXED      = 4'd8,
        PH_ADATA       = 4'd9,
        PH_DONE        = 4'd10,
        PH_ERR_NOTRESP = 4'd11,
        PH_ERR_RCODE   = 4'd12
    } phase_t;

    // Result kinds
    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT_HDR = 3'd1;
    localparam logic [2:0] STATUS_NOT_RESP  = 3'd2;
    localparam logic [2:0] STATUS_RCODE     = 3'd3;
    localparam logic [2:0] STATUS_TRUNC     = 3'd4;

    // Message layout
    localparam logic [15:0] HEADER_LEN  = 16'd12;
    localparam logic [15:0] QFIXED_LEN  = 16'd4;
    localparam logic [15:0] AFIXED_LEN  = 16'd10;
    localparam logic [1:0]  PTR_MARK    = 2'b11;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] CLASS_IN    = 16'd1;
    localparam logic [15:0] A_RDLENGTH  = 16'd4;

    localparam logic [7:0] MAX_ADDR_RESET = 8'd16;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        kind;
        logic [31:0] ipv4_address;
        logic [2:0]  status;
        logic [7:0]  address_count;
        logic        run_last;
    } result_t;

    // Up to two results raised by one byte: an address, then a status.
    typedef struct packed {
        logic    addr_valid;
        logic    stat_valid;
        result_t addr_item;
        result_t stat_item;
    } push_t;

endpackage

// ----- src/dae_parser.sv -----
// Byte-wise DNS response parser: parse state and per-byte update.
module dae_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          msg_byte,
    input  logic                msg_last,
    input  logic [7:0]          max_addresses,
    output dae_pkg::push_t      push
);

    dae_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rclass_reg, rclass_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [31:0] addr_reg, addr_next;
    logic [7:0]  found_reg, found_next;

    logic [15:0] pos_inc;
    logic [15:0] aleft_dec;
    logic [15:0] qleft_dec;
    logic [7:0]  found_inc;
    logic        addr_hit;
    logic [2:0]  stat_code;

    assign pos_inc   = pos_reg + 16'd1;
    assign aleft_dec = aleft_reg - 16'd1;
    assign qleft_dec = qleft_reg - 16'd1;
    assign found_inc = found_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        flags_next  = flags_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        rtype_next  = rtype_reg;
        rclass_next = rclass_reg;
        dlen_next   = dlen_reg;
        addr_next   = addr_reg;
        found_next  = found_reg;
        addr_hit    = 1'b0;
        stat_code   = dae_pkg::STATUS_TRUNC;

        unique case (phase_reg)
            dae_pkg::PH_HEADER:
            begin
                // bytes 2..3 flags, 4..5 QDCOUNT, 6..7 ANCOUNT
                if (pos_reg == 16'd2 || pos_reg == 16'd3)
                    flags_next = {flags_reg[7:0], msg_byte};
                else if (pos_reg == 16'd4 || pos_reg == 16'd5)
                    qleft_next = {qleft_reg[7:0], msg_byte};
                else if (pos_reg == 16'd6 || pos_reg == 16'd7)
                    aleft_next = {aleft_reg[7:0], msg_byte};
                pos_next = pos_inc;
                if (pos_inc >= dae_pkg::HEADER_LEN)
                begin
                    pos_next = '0;
                    if (!flags_next[15])
                        phase_next = dae_pkg::PH_ERR_NOTRESP;
                    else if (flags_next[3:0] != 4'd0)
                        phase_next = dae_pkg::PH_ERR_RCODE;
                    else if (aleft_next == 16'd0)
                        phase_next = dae_pkg::PH_DONE;
                    else if (qleft_next != 16'd0)
                        phase_next = dae_pkg::PH_QNAME;
                    else if (found_reg < max_addresses)
                        phase_next = dae_pkg::PH_ANAME;
                    else
                        phase_next = dae_pkg::PH_DONE;
                end
            end
            dae_pkg::PH_QNAME, dae_pkg::PH_ANAME:
            begin
                if (msg_byte[7:6] == dae_pkg::PTR_MARK)
                begin
                    phase_next = (phase_reg == dae_pkg::PH_QNAME) ?
                                 dae_pkg::PH_QPTR : dae_pkg::PH_APTR;
                end
                else if (msg_byte == 8'd0)
                begin
                    phase_next = (phase_reg == dae_pkg::PH_QNAME) ?
                                 dae_pkg::PH_QFIXED : dae_pkg::PH_AFIXED;
                    pos_next   = '0;
                end
                else
                begin
                    phase_next = (phase_reg == dae_pkg::PH_QNAME) ?
                                 dae_pkg::PH_QLABEL : dae_pkg::PH_ALABEL;
                    pos_next   = {8'd0, msg_byte};
                end
            end
            dae_pkg::PH_QPTR:
            begin
                phase_next = dae_pkg::PH_QFIXED;
                pos_next   = '0;
            end
            dae_pkg::PH_APTR:
            begin
                phase_next = dae_pkg::PH_AFIXED;
                pos_next   = '0;
            end
            dae_pkg::PH_QLABEL, dae_pkg::PH_ALABEL:
            begin
                pos_next = pos_reg - 16'd1;
                if (pos_next == 16'd0)
                    phase_next = (phase_reg == dae_pkg::PH_QLABEL) ?
                                 dae_pkg::PH_QNAME : dae_pkg::PH_ANAME;
            end
            dae_pkg::PH_QFIXED:
            begin
                pos_next = pos_inc;
                if (pos_inc >= dae_pkg::QFIXED_LEN)
                begin
                    pos_next   = '0;
                    qleft_next = qleft_dec;
                    if (qleft_dec != 16'd0)
                        phase_next = dae_pkg::PH_QNAME;
                    else if (aleft_reg != 16'd0 && found_reg < max_addresses)
                        phase_next = dae_pkg::PH_ANAME;
                    else
                        phase_next = dae_pkg::PH_DONE;
                end
            end
            dae_pkg::PH_AFIXED:
            begin
                // type, class, TTL (skipped), rdlength
                if (pos_reg < 16'd2)
                    rtype_next = {rtype_reg[7:0], msg_byte};
                else if (pos_reg < 16'd4)
                    rclass_next = {rclass_reg[7:0], msg_byte};
                else if (pos_reg >= 16'd8)
                    dlen_next = {dlen_reg[7:0], msg_byte};
                pos_next = pos_inc;
                if (pos_inc >= dae_pkg::AFIXED_LEN)
                begin
                    pos_next  = '0;
                    addr_next = '0;
                    if (dlen_next == 16'd0)
                    begin
                        aleft_next = aleft_dec;
                        phase_next = (aleft_dec != 16'd0 && found_reg < max_addresses) ?
                                     dae_pkg::PH_ANAME : dae_pkg::PH_DONE;
                    end
                    else
                        phase_next = dae_pkg::PH_ADATA;
                end
            end
            dae_pkg::PH_ADATA:
            begin
                addr_next = {addr_reg[23:0], msg_byte};
                pos_next  = pos_inc;
                if (pos_inc >= dlen_reg)
                begin
                    pos_next = '0;
                    if (rtype_reg == dae_pkg::TYPE_A && rclass_reg == dae_pkg::CLASS_IN &&
                        dlen_reg == dae_pkg::A_RDLENGTH)
                    begin
                        addr_hit   = 1'b1;
                        found_next = found_inc;
                    end
                    aleft_next = aleft_dec;
                    phase_next = (aleft_dec != 16'd0 && found_next < max_addresses) ?
                                 dae_pkg::PH_ANAME : dae_pkg::PH_DONE;
                end
            end
            dae_pkg::PH_DONE, dae_pkg::PH_ERR_NOTRESP, dae_pkg::PH_ERR_RCODE:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = dae_pkg::PH_DONE;
            end
        endcase

        unique case (phase_next)
            dae_pkg::PH_HEADER:      stat_code = dae_pkg::STATUS_SHORT_HDR;
            dae_pkg::PH_DONE:        stat_code = dae_pkg::STATUS_OK;
            dae_pkg::PH_ERR_NOTRESP: stat_code = dae_pkg::STATUS_NOT_RESP;
            dae_pkg::PH_ERR_RCODE:   stat_code = dae_pkg::STATUS_RCODE;
            default:                 stat_code = dae_pkg::STATUS_TRUNC;
        endcase

        push.addr_valid              = in_fire && addr_hit;
        push.addr_item.kind          = dae_pkg::KIND_ADDRESS;
        push.addr_item.ipv4_address  = addr_next;
        push.addr_item.status        = dae_pkg::STATUS_OK;
        push.addr_item.address_count = 8'd0;
        push.addr_item.run_last      = !msg_last;

        push.stat_valid              = in_fire && msg_last;
        push.stat_item.kind          = dae_pkg::KIND_STATUS;
        push.stat_item.ipv4_address  = 32'd0;
        push.stat_item.status        = stat_code;
        push.stat_item.address_count = found_next;
        push.stat_item.run_last      = 1'b1;

        // end of message: back to a clean header
        if (msg_last)
        begin
            phase_next  = dae_pkg::PH_HEADER;
            pos_next    = '0;
            flags_next  = '0;
            qleft_next  = '0;
            aleft_next  = '0;
            rtype_next  = '0;
            rclass_next = '0;
            dlen_next   = '0;
            addr_next   = '0;
            found_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dae_pkg::PH_HEADER;
            pos_reg    <= '0;
            flags_reg  <= '0;
            qleft_reg  <= '0;
            aleft_reg  <= '0;
            rtype_reg  <= '0;
            rclass_reg <= '0;
            dlen_reg   <= '0;
            addr_reg   <= '0;
            found_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            qleft_reg  <= qleft_next;
            aleft_reg  <= aleft_next;
            rtype_reg  <= rtype_next;
            rclass_reg <= rclass_next;
            dlen_reg   <= dlen_next;
            addr_reg   <= addr_next;
            found_reg  <= found_next;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && msg_last |=> phase_reg == dae_pkg::PH_HEADER && found_reg == 8'd0)
        else $error("message state not cleared after final byte");

    a_addr_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        push.addr_valid |-> phase_reg == dae_pkg::PH_ADATA && found_reg < max_addresses)
        else $error("address raised outside record data");
`endif

endmodule

// ----- src/dae_result_fifo.sv -----
// Four-entry result queue taking up to two items per cycle.
module dae_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  dae_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output dae_pkg::result_t  out_item
);

    dae_pkg::result_t mem_reg [dae_pkg::FIFO_DEPTH];

    logic [dae_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dae_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dae_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [dae_pkg::FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [1:0]                     push_n;
    logic                           pop;

    assign wr_ptr_plus1 = dae_pkg::FIFO_PTR_W'(wr_ptr_reg + 1'b1);
    assign push_n       = {1'b0, push.addr_valid} + {1'b0, push.stat_valid};
    assign pop          = out_valid && out_ready;

    // room for a worst-case byte (two results)
    assign room      = count_reg <= dae_pkg::FIFO_CNT_W'(dae_pkg::FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = dae_pkg::FIFO_PTR_W'(wr_ptr_reg + push_n);
        rd_ptr_next = dae_pkg::FIFO_PTR_W'(rd_ptr_reg + pop);
        count_next  = dae_pkg::FIFO_CNT_W'(count_reg + push_n - pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.addr_valid && push.stat_valid)
        begin
            mem_reg[wr_ptr_reg]   <= push.addr_item;
            mem_reg[wr_ptr_plus1] <= push.stat_item;
        end
        else if (push.addr_valid)
            mem_reg[wr_ptr_reg] <= push.addr_item;
        else if (push.stat_valid)
            mem_reg[wr_ptr_reg] <= push.stat_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.addr_valid || push.stat_valid) |->
            count_reg <= dae_pkg::FIFO_CNT_W'(dae_pkg::FIFO_DEPTH - 2))
        else $error("result queue written without room");

    a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == dae_pkg::FIFO_CNT_W'(0) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");
`endif

endmodule

// ----- src/dns_a_record_extractor.sv -----
// Top level of the DNS response A-record extractor.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_ready     msg_byte, msg_last
//  out       source     out_valid / out_ready   result_kind, ipv4_address, status,
//                                               address_count, run_last
//  cfg       sink       cfg_valid / cfg_ready   max_addresses
//
// One byte is taken per cycle while in_ready is high; the parser state
// updates at the accepting edge. Each byte raises zero, one or two results
// into a four-entry queue; in_ready drops only while fewer than two queue
// slots are free. Results leave the queue one per cycle while out_ready is high.
// Reset (rst_n low, asynchronous) empties the queue, returns the parser to the
// header and sets the address limit to 16. cfg_ready is always high.
module dns_a_record_extractor
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        msg_last,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [31:0] ipv4_address,
    output logic [2:0]  status,
    output logic [7:0]  address_count,
    output logic        run_last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  max_addresses
);

    logic [7:0]       max_addr_q_reg;
    logic             in_fire;
    logic             room;
    dae_pkg::push_t   push;
    dae_pkg::result_t head;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign in_fire   = in_valid && room;

    // address limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_addr_q_reg <= dae_pkg::MAX_ADDR_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_addr_q_reg <= max_addresses;
            end
        end
    end

    dae_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .msg_byte      (msg_byte),
        .msg_last      (msg_last),
        .max_addresses (max_addr_q_reg),
        .push          (push)
    );

    dae_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (head)
    );

    assign result_kind   = head.kind;
    assign ipv4_address  = head.ipv4_address;
    assign status        = head.status;
    assign address_count = head.address_count;
    assign run_last      = head.run_last;

`ifndef SYNTHESIS
    a_limit_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> max_addr_q_reg == $past(max_addresses))
        else $error("address limit not taken from config write");
`endif

endmodule

// ----- tb/sv/dae_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the DNS A-record extractor: tracks the parse and compares every result.
module dae_result_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        msg_last,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [31:0] ipv4_address,
    input  logic [2:0]  status,
    input  logic [7:0]  address_count,
    input  logic        run_last,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  max_addresses,

    output int          failures,
    output int          results_outstanding
);

    dae_pkg::phase_t  phase;
    logic [15:0]      field_pos;
    logic [15:0]      hdr_flags;
    logic [15:0]      qd_left;
    logic [15:0]      an_left;
    logic [15:0]      rr_type;
    logic [15:0]      rr_class;
    logic [15:0]      rd_len;
    logic [31:0]      addr_acc;
    logic [7:0]       found;
    logic [7:0]       addr_limit;

    dae_pkg::result_t expected_results[$];

    task automatic clear_parse();
        phase     = dae_pkg::PH_HEADER;
        field_pos = '0;
        hdr_flags = '0;
        qd_left   = '0;
        an_left   = '0;
        rr_type   = '0;
        rr_class  = '0;
        rd_len    = '0;
        addr_acc  = '0;
        found     = '0;
    endtask

    // Answer loop: carry on while answers remain and the limit is not reached.
    task automatic next_answer();
        phase = (an_left != 16'd0 && found < addr_limit) ? dae_pkg::PH_ANAME
                                                        : dae_pkg::PH_DONE;
    endtask

    task automatic next_question();
        if (qd_left != 16'd0)
            phase = dae_pkg::PH_QNAME;
        else
            next_answer();
    endtask

    task automatic name_byte(input logic [7:0] b, input dae_pkg::phase_t ptr_ph,
                             input dae_pkg::phase_t lab_ph,
                             input dae_pkg::phase_t end_ph);
        if (b[7:6] == dae_pkg::PTR_MARK)
            phase = ptr_ph;
        else if (b == 8'h00)
        begin
            phase     = end_ph;
            field_pos = '0;
        end
        else
        begin
            field_pos = {8'h00, b};
            phase     = lab_ph;
        end
    endtask

    task automatic close_record();
        an_left = an_left - 16'd1;
        next_answer();
    endtask

    // Advance the parse by one byte and queue the results it raises.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        dae_pkg::result_t addr_res;
        dae_pkg::result_t stat_res;
        logic             addr_hit;
        addr_hit = 1'b0;
        addr_res = '0;
        stat_res = '0;
        case (phase)
            dae_pkg::PH_HEADER:
            begin
                if (field_pos == 16'd2 || field_pos == 16'd3)
                    hdr_flags = {hdr_flags[7:0], b};
                else if (field_pos == 16'd4 || field_pos == 16'd5)
                    qd_left = {qd_left[7:0], b};
                else if (field_pos == 16'd6 || field_pos == 16'd7)
                    an_left = {an_left[7:0], b};
                field_pos = field_pos + 16'd1;
                if (field_pos >= dae_pkg::HEADER_LEN)
                begin
                    field_pos = '0;
                    if (!hdr_flags[15])
                        phase = dae_pkg::PH_ERR_NOTRESP;
                    else if (hdr_flags[3:0] != 4'h0)
                        phase = dae_pkg::PH_ERR_RCODE;
                    else if (an_left == 16'd0)
                        phase = dae_pkg::PH_DONE;
                    else
                        next_question();
                end
            end
            dae_pkg::PH_QNAME:
                name_byte(b, dae_pkg::PH_QPTR, dae_pkg::PH_QLABEL, dae_pkg::PH_QFIXED);
            dae_pkg::PH_QPTR:
            begin
                phase     = dae_pkg::PH_QFIXED;
                field_pos = '0;
            end
            dae_pkg::PH_QLABEL:
            begin
                field_pos = field_pos - 16'd1;
                if (field_pos == 16'd0)
                    phase = dae_pkg::PH_QNAME;
            end
            dae_pkg::PH_QFIXED:
            begin
                field_pos = field_pos + 16'd1;
                if (field_pos >= dae_pkg::QFIXED_LEN)
                begin
                    field_pos = '0;
                    qd_left   = qd_left - 16'd1;
                    next_question();
                end
            end
            dae_pkg::PH_ANAME:
                name_byte(b, dae_pkg::PH_APTR, dae_pkg::PH_ALABEL, dae_pkg::PH_AFIXED);
            dae_pkg::PH_APTR:
            begin
                phase     = dae_pkg::PH_AFIXED;
                field_pos = '0;
            end
            dae_pkg::PH_ALABEL:
            begin
                field_pos = field_pos - 16'd1;
                if (field_pos == 16'd0)
                    phase = dae_pkg::PH_ANAME;
            end
            dae_pkg::PH_AFIXED:
            begin
                if (field_pos < 16'd2)
                    rr_type = {rr_type[7:0], b};
                else if (field_pos < 16'd4)
                    rr_class = {rr_class[7:0], b};
                else if (field_pos >= 16'd8)
                    rd_len = {rd_len[7:0], b};
                field_pos = field_pos + 16'd1;
                if (field_pos >= dae_pkg::AFIXED_LEN)
                begin
                    field_pos = '0;
                    addr_acc  = '0;
                    if (rd_len == 16'd0)
                        close_record();
                    else
                        phase = dae_pkg::PH_ADATA;
                end
            end
            dae_pkg::PH_ADATA:
            begin
                addr_acc  = {addr_acc[23:0], b};
                field_pos = field_pos + 16'd1;
                if (field_pos >= rd_len)
                begin
                    field_pos = '0;
                    if (rr_type == dae_pkg::TYPE_A && rr_class == dae_pkg::CLASS_IN &&
                        rd_len == dae_pkg::A_RDLENGTH)
                    begin
                        addr_hit              = 1'b1;
                        addr_res.kind         = dae_pkg::KIND_ADDRESS;
                        addr_res.ipv4_address = addr_acc;
                        found                 = found + 8'd1;
                    end
                    close_record();
                end
            end
            dae_pkg::PH_DONE, dae_pkg::PH_ERR_NOTRESP, dae_pkg::PH_ERR_RCODE:
            begin
            end
            default:
                phase = dae_pkg::PH_DONE;
        endcase

        if (fin)
        begin
            stat_res.kind = dae_pkg::KIND_STATUS;
            case (phase)
                dae_pkg::PH_HEADER:      stat_res.status = dae_pkg::STATUS_SHORT_HDR;
                dae_pkg::PH_DONE:        stat_res.status = dae_pkg::STATUS_OK;
                dae_pkg::PH_ERR_NOTRESP: stat_res.status = dae_pkg::STATUS_NOT_RESP;
                dae_pkg::PH_ERR_RCODE:   stat_res.status = dae_pkg::STATUS_RCODE;
                default:                 stat_res.status = dae_pkg::STATUS_TRUNC;
            endcase
            stat_res.address_count = found;
            stat_res.run_last      = 1'b1;
            clear_parse();
        end
        else
            addr_res.run_last = 1'b1;

        if (addr_hit)
            expected_results.push_back(addr_res);
        if (fin)
            expected_results.push_back(stat_res);
    endtask

    // Everything moves on rising edges only, so the values seen at the falling
    // edge are the ones the next rising edge will take.
    always @(negedge clk or negedge rst_n)
    begin
        dae_pkg::result_t seen;
        dae_pkg::result_t want;
        if (!rst_n)
        begin
            clear_parse();
            addr_limit = dae_pkg::MAX_ADDR_RESET;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.kind          = result_kind;
                seen.ipv4_address  = ipv4_address;
                seen.status        = status;
                seen.address_count = address_count;
                seen.run_last      = run_last;
                if (expected_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"%t unexpected result: kind %0d addr %h ",
                                  "status %0d count %0d last %0d"},
                                 $time, seen.kind, seen.ipv4_address, seen.status,
                                 seen.address_count, seen.run_last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%t result mismatch: expected kind %0d addr %h ",
                                      "status %0d count %0d last %0d, got kind %0d ",
                                      "addr %h status %0d count %0d last %0d"},
                                     $time, want.kind, want.ipv4_address, want.status,
                                     want.address_count, want.run_last, seen.kind,
                                     seen.ipv4_address, seen.status, seen.address_count,
                                     seen.run_last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                addr_limit = max_addresses;
            if (in_valid && in_ready)
                parse_byte(msg_byte, msg_last);
        end
        results_outstanding = expected_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench top for the DNS A-record extractor: clock, reset, message stimulus and verdict.
module testbench;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEGMENT_BYTES = 140;   // bytes of random messages per limit setting
    localparam int SEGMENTS      = 6;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;

    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [7:0]  msg_byte      = 8'h00;
    logic        msg_last      = 1'b0;

    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        result_kind;
    logic [31:0] ipv4_address;
    logic [2:0]  status;
    logic [7:0]  address_count;
    logic        run_last;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [7:0]  max_addresses = 8'h00;

    int          failures;
    int          results_outstanding;
    int          cycles;

    // Idle rates in percent, changed between phases of the run.
    int          send_idle_pct = 14;
    int          recv_idle_pct = 45;

    // Bytes of the message about to be sent.
    logic [7:0]  reply_bytes[$];

    dns_a_record_extractor DUT
    (
        .clk, .rst_n,
        .in_valid, .in_ready, .msg_byte, .msg_last,
        .out_valid, .out_ready, .result_kind, .ipv4_address, .status,
        .address_count, .run_last,
        .cfg_valid, .cfg_ready, .max_addresses
    );

    dae_result_checker checker_inst
    (
        .clk, .rst_n,
        .in_valid, .in_ready, .msg_byte, .msg_last,
        .out_valid, .out_ready, .result_kind, .ipv4_address, .status,
        .address_count, .run_last,
        .cfg_valid, .cfg_ready, .max_addresses,
        .failures, .results_outstanding
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: ready drops at random, one decision per cycle.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One byte per call. An idle gap may come first; valid then holds until the
    // item is taken. Handshakes are judged at the falling edge, where all
    // signals have settled for the coming rising edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        logic took;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        msg_byte <= b;
        msg_last <= fin;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // The final byte of the message carries the last flag.
    task automatic send_reply();
        foreach (reply_bytes[i])
            send_byte(reply_bytes[i], i == reply_bytes.size() - 1);
    endtask

    // Drop valid and let every expected result come out; spare idle cycles
    // follow so the parser has settled before the limit is touched.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        logic took;
        cfg_valid     <= 1'b1;
        max_addresses <= v;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_word(input logic [15:0] w);
        reply_bytes.push_back(w[15:8]);
        reply_bytes.push_back(w[7:0]);
    endtask

    // A domain name: zero to three labels, ended by a root byte or a compression
    // pointer. Now and then a label length has top bits 01 or 10, which the
    // block must treat as a plain (long) length.
    task automatic add_name();
        int labels;
        int len;
        labels = $urandom_range(0, 3);
        repeat (labels)
        begin
            if ($urandom_range(0, 24) == 0)
                len = $urandom_range(64, 191);
            else
                len = $urandom_range(1, 12);
            reply_bytes.push_back(8'(len));
            repeat (len) reply_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            reply_bytes.push_back(8'($urandom_range(192, 255)));
            reply_bytes.push_back(8'($urandom));
        end
        else
            reply_bytes.push_back(8'h00);
    endtask

    // Mostly well-formed responses with random content; the rest is noise,
    // non-responses, rcode errors and messages cut short.
    task automatic make_reply();
        int          roll;
        int          qd;
        int          an;
        int          cut;
        logic [15:0] flags;
        logic [15:0] rr_type;
        logic [15:0] rr_class;
        logic [15:0] rd_len;
        reply_bytes.delete();
        roll = $urandom_range(0, 99);
        if (roll < 10)
            repeat ($urandom_range(1, 30)) reply_bytes.push_back(8'($urandom));
        else
        begin
            flags = 16'($urandom);
            roll  = $urandom_range(0, 99);
            flags[15] = (roll >= 8);
            if (roll >= 16)
                flags[3:0] = 4'h0;
            else if (roll >= 8)
                flags[3:0] = 4'($urandom_range(1, 15));
            qd = $urandom_range(0, 2);
            an = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            add_word(16'($urandom));
            add_word(flags);
            add_word(16'(qd));
            add_word(16'(an));
            add_word(16'($urandom));
            add_word(16'($urandom));
            repeat (qd)
            begin
                add_name();
                add_word(16'($urandom));
                add_word(16'($urandom));
            end
            repeat (an)
            begin
                add_name();
                if ($urandom_range(0, 4) != 0)
                    rr_type = dae_pkg::TYPE_A;
                else
                    rr_type = ($urandom_range(0, 1) == 1) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3));
                if ($urandom_range(0, 5) != 0)
                    rr_class = dae_pkg::CLASS_IN;
                else
                    rr_class = ($urandom_range(0, 1) == 1) ? 16'($urandom)
                                                           : 16'($urandom_range(0, 3));
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    rd_len = dae_pkg::A_RDLENGTH;
                else if (roll < 82)
                    rd_len = 16'd0;
                else if (roll < 98)
                    rd_len = 16'($urandom_range(1, 8));
                else
                    rd_len = 16'($urandom_range(256, 259));   // high length byte set
                add_word(rr_type);
                add_word(rr_class);
                add_word(16'($urandom));
                add_word(16'($urandom));
                add_word(rd_len);
                repeat (rd_len) reply_bytes.push_back(8'($urandom));
            end
            // trailing bytes past the last record are ignored by the parser
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) reply_bytes.push_back(8'($urandom));
            // cut short anywhere: inside the header, a question or an answer
            if ($urandom_range(0, 99) < 15)
            begin
                cut = $urandom_range(1, reply_bytes.size() - 1);
                while (reply_bytes.size() > cut)
                    void'(reply_bytes.pop_back());
            end
        end
    endtask

    initial
    begin
        int         seg;
        int         sent;
        logic [7:0] limit;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages, with the limit at its reset value.
        // One byte only: ends inside the header.
        reply_bytes = '{8'hFF};
        send_reply();
        // All-zero header: QR clear, so not a response.
        reply_bytes.delete();
        repeat (12) reply_bytes.push_back(8'h00);
        send_reply();
        // Response with a nonzero rcode.
        reply_bytes = '{8'h12, 8'h34, 8'h80, 8'h0F, 8'h00, 8'h01, 8'h00, 8'h01,
                        8'h00, 8'h00, 8'h00, 8'h00};
        send_reply();
        // One question behind a pointer, one IN A answer, then a CNAME-type
        // answer with a root name and empty data; the message ends on its
        // length byte, so the status is ok with one address.
        reply_bytes = '{8'hFF, 8'hFF, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h02,
                        8'h00, 8'h00, 8'h00, 8'h00,
                        8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
                        8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                        8'h0E, 8'h10, 8'h00, 8'h04, 8'hC0, 8'hA8, 8'h01, 8'hFE,
                        8'h00, 8'h00, 8'h05, 8'h00, 8'h01, 8'h7F, 8'hFF, 8'hFF,
                        8'hFF, 8'h00, 8'h00};
        send_reply();

        // Random messages in segments, each under its own address limit.
        // Sender idles more in the middle third, nobody idles in the last.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 14;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0:       limit = 8'd255;
                1:       limit = 8'd0;
                2:       limit = 8'd2;
                3:       limit = 8'd1;
                4:       limit = 8'($urandom_range(3, 254));
                default: limit = 8'd3;
            endcase
            wait_drained();
            write_limit(limit);
            sent = 0;
            while (sent < SEGMENT_BYTES)
            begin
                make_reply();
                sent += reply_bytes.size();
                send_reply();
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (failures == 0 && results_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- dns_a_record_extractor.f -----
src/dae_pkg.sv
src/dae_parser.sv
src/dae_result_fifo.sv
src/dns_a_record_extractor.sv
tb/sv/dae_result_checker.sv
tb/sv/testbench.sv
